FILE: src/vmca_pkg.sv
// Package: opcodes, status codes, shared types and defaults for the checked ALU.
package vmca_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned QUEUE_DEPTH_D = 4;
    localparam int unsigned OUT_DEPTH_D   = 4;

    typedef enum logic [2:0]
    {
        OP_NOP = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_AND = 3'd5,
        OP_OR  = 3'd6,
        OP_XOR = 3'd7
    } op_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_BADPARAM  = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    // Classified instruction handed from front to back.
    typedef struct packed
    {
        op_t                 op;
        logic                sgn;
        logic                pre_err;  // status decided in the front
        status_t             pre_st;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
    } instr_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] result;
        logic              write_dest;
        status_t           status;
    } res_t;

endpackage

FILE: src/vmca_front.sv
// Front end: accepts instructions, checks params and operand-only errors.
module vmca_front
    import vmca_pkg::*;
(
    input  logic [2:0]        action,
    input  logic [7:0]        param,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output instr_t            instr
);
    logic arith;
    logic smin;

    always_comb
    begin
        arith = (action == OP_ADD) || (action == OP_SUB) ||
                (action == OP_MUL) || (action == OP_DIV);
        smin  = (operand_a == {1'b1, {(DATA_W-1){1'b0}}}) && (&operand_b);
        instr.op      = op_t'(action);
        instr.sgn     = (param == 8'd1);
        instr.a       = operand_a;
        instr.b       = operand_b;
        instr.pre_err = 1'b0;
        instr.pre_st  = ST_OK;
        if (action == OP_NOP)
        begin
            instr.pre_err = 1'b1;
        end
        else if ((arith && param > 8'd1) || (!arith && param != 8'd0))
        begin
            instr.pre_err = 1'b1;
            instr.pre_st  = ST_BADPARAM;
        end
        else if (action == OP_DIV && operand_b == '0)
        begin
            instr.pre_err = 1'b1;
            instr.pre_st  = ST_DIVZERO;
        end
        else if (action == OP_DIV && param == 8'd1 && smin)
        begin
            instr.pre_err = 1'b1;
            instr.pre_st  = ST_OVERFLOW;
        end
        else if (action == OP_SUB && param == 8'd0 && operand_b > operand_a)
        begin
            instr.pre_err = 1'b1;
            instr.pre_st  = ST_UNDERFLOW;
        end
    end
endmodule

FILE: src/vmca_fifo.sv
// Small synchronous FIFO with registered storage.
module vmca_fifo
    import vmca_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_D,
    parameter int unsigned WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end
endmodule

FILE: src/vmca_back.sv
// Back end: pipelined execute (multiply, radix-2 divide) with in-order results.
module vmca_back
    import vmca_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  instr_t in_instr,
    output logic   in_ready,
    output logic   out_valid,
    output res_t   out_res,
    input  logic   out_ready
);
    // Stage 0: add/sub/logic result and divider setup; then DATA_W divide steps;
    // multiply is split over 16x16 partial products and carried along.
    localparam int unsigned NST = DATA_W + 2;

    typedef struct packed
    {
        logic              v;
        instr_t            ins;
        logic [DATA_W-1:0] res;
        logic              ovf;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dv;
        logic              neg;
    } pst_t;

    pst_t st_reg [NST];
    pst_t s0;
    logic adv;

    assign adv      = !st_reg[NST-1].v || out_ready;
    assign in_ready = adv;

    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] ma, mb;
    always_comb
    begin
        s0     = '0;
        s0.v   = in_valid;
        s0.ins = in_instr;
        sum    = {1'b0, in_instr.a} + {1'b0, in_instr.b};
        ma     = (in_instr.sgn && in_instr.a[DATA_W-1]) ? -in_instr.a : in_instr.a;
        mb     = (in_instr.sgn && in_instr.b[DATA_W-1]) ? -in_instr.b : in_instr.b;
        case (in_instr.op)
            OP_ADD:
            begin
                s0.res = sum[DATA_W-1:0];
                s0.ovf = in_instr.sgn ?
                    ((in_instr.a[DATA_W-1] == in_instr.b[DATA_W-1]) &&
                     (sum[DATA_W-1] != in_instr.a[DATA_W-1])) : sum[DATA_W];
            end
            OP_SUB:  s0.res = in_instr.a - in_instr.b;
            OP_MUL:  s0.res = {16'h0, in_instr.a[15:0]} * {16'h0, in_instr.b[15:0]};
            OP_AND:  s0.res = in_instr.a & in_instr.b;
            OP_OR:   s0.res = in_instr.a | in_instr.b;
            OP_XOR:  s0.res = in_instr.a ^ in_instr.b;
            default: s0.res = '0;
        endcase
        s0.quo = ma;
        s0.dv  = mb;
        s0.neg = in_instr.sgn && (in_instr.a[DATA_W-1] ^ in_instr.b[DATA_W-1]);
    end

    // Stage 1 adds the cross partial products of the multiply.
    pst_t s1;
    always_comb
    begin
        s1 = st_reg[0];
        if (st_reg[0].ins.op == OP_MUL)
        begin
            s1.res = st_reg[0].res
                   + {st_reg[0].ins.a[15:0] * st_reg[0].ins.b[31:16], 16'h0}
                   + {st_reg[0].ins.a[31:16] * st_reg[0].ins.b[15:0], 16'h0};
        end
    end

    // Restoring divide: one quotient bit per stage.
    pst_t sd [DATA_W];
    logic [DATA_W:0] trial [DATA_W];
    always_comb
    begin
        for (int i = 0; i < DATA_W; i++)
        begin
            sd[i]    = st_reg[i+1];
            trial[i] = {sd[i].rem, sd[i].quo[DATA_W-1]} - {1'b0, sd[i].dv};
            if (!trial[i][DATA_W])
            begin
                sd[i].rem = trial[i][DATA_W-1:0];
                sd[i].quo = {sd[i].quo[DATA_W-2:0], 1'b1};
            end
            else
            begin
                sd[i].rem = {sd[i].rem[DATA_W-2:0], sd[i].quo[DATA_W-1]};
                sd[i].quo = {sd[i].quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                st_reg[i].v <= 1'b0;
            end
        end
        else if (adv)
        begin
            st_reg[0] <= s0;
            st_reg[1] <= s1;
            for (int i = 0; i < DATA_W; i++)
            begin
                if (i + 2 < NST)
                begin
                    st_reg[i+2] <= sd[i];
                end
            end
        end
    end

    pst_t fin;
    status_t fst;
    logic [DATA_W-1:0] fres;
    always_comb
    begin
        fin = st_reg[NST-1];
        fst = fin.ins.pre_st;
        if (!fin.ins.pre_err && fin.ins.op == OP_ADD && fin.ovf)
        begin
            fst = ST_OVERFLOW;
        end
        fres = fin.res;
        if (fin.ins.op == OP_DIV)
        begin
            fres = fin.neg ? -fin.quo : fin.quo;
        end
        out_valid          = fin.v;
        out_res.status     = fst;
        out_res.write_dest = !fin.ins.pre_err && fst == ST_OK;
        out_res.result     = out_res.write_dest ? fres : '0;
    end
endmodule

FILE: src/vm_checked_alu.sv
// Top level: checked VM ALU, front classifier + queue + pipelined execute + result queue.
//
// Channel   Dir   Handshake          Payload
// input     in    push / full        action, param, operand_a, operand_b
// result    out   pop / empty        result, write_dest, status
//
// One transaction per cycle sustained while the result side does not stall; the pipeline
// depth is set by the radix-2 divider (one quotient bit per stage).
// Reset (rst_n low, asynchronous) empties both queues and the pipeline.
// A stalled result side fills the result queue and stalls the pipeline, then fills the
// instruction queue; full rises only when the instruction queue is full.
module vm_checked_alu
    import vmca_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D,
    parameter int unsigned OUT_DEPTH   = OUT_DEPTH_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        action,
    input  logic [7:0]        param,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output logic              empty,
    input  logic              pop,
    output logic [DATA_W-1:0] result,
    output logic              write_dest,
    output logic [2:0]        status
);
    instr_t front_instr, q_instr;
    logic   q_empty, q_full, be_ready, be_valid;
    res_t   be_res, out_res;
    logic   oq_full;

    // Front: classify and catch errors that depend only on the operands.
    vmca_front u_front
    (
        .action    (action),
        .param     (param),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .instr     (front_instr)
    );

    // Decoupling queue between front and back.
    vmca_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(instr_t))) u_iq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_instr),
        .rd_en   (be_ready),
        .rd_data (q_instr),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign full = q_full;

    vmca_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_instr  (q_instr),
        .in_ready  (be_ready),
        .out_valid (be_valid),
        .out_res   (be_res),
        .out_ready (!oq_full)
    );

    // Result queue: the result side sees it as a plain FIFO.
    vmca_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(res_t))) u_oq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (be_valid),
        .wr_data (be_res),
        .rd_en   (pop),
        .rd_data (out_res),
        .full    (oq_full),
        .empty   (empty)
    );

    assign result     = out_res.result;
    assign write_dest = out_res.write_dest;
    assign status     = out_res.status;
endmodule

FILE: sim/vm_checked_alu_test.sv
// Testbench for the checked VM ALU: directed table, then random traffic, checked by a predictor.
`timescale 1ns / 100ps

module vm_checked_alu_test;
    import vmca_pkg::*;

    localparam int unsigned N_RANDOM  = 1100;
    localparam int unsigned MAX_CYCLE = 400000;
    localparam int unsigned TAIL      = 60;

    typedef struct
    {
        op_t         op;
        logic [7:0]  param;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;   // expected result typed into the table
        logic [31:0] result;
        logic        wr;
        status_t     st;
    } vector_t;

    typedef struct
    {
        logic [31:0] result;
        logic        wr;
        status_t     st;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  action = '0;
    logic [7:0]  param = '0;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] result;
    logic        write_dest;
    logic [2:0]  status;

    outcome_t pending_outcomes[$];
    int       n_errors = 0;
    int       cycle = 0;
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       hold_off = 0;      // cycles the receiver must still refuse pops

    vm_checked_alu i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .param      (param),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .write_dest (write_dest),
        .status     (status)
    );

    always #10 clk = ~clk;

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Predict one ALU instruction. Every instruction yields exactly one outcome.
    function automatic outcome_t alu_outcome(op_t op, logic [7:0] prm,
                                             logic [31:0] a, logic [31:0] b);
        outcome_t    o;
        logic        arith;
        logic        sgn;
        logic [32:0] wide;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        o.result = '0;
        o.st     = ST_OK;
        arith    = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
        sgn      = (prm == 8'd1);
        if (op == OP_NOP)
        begin
            o.wr = 1'b0;
            return o;
        end
        if ((arith && prm > 8'd1) || (!arith && prm != 8'd0))
            o.st = ST_BADPARAM;
        else
        begin
            case (op)
                OP_ADD:
                begin
                    wide     = {1'b0, a} + {1'b0, b};
                    o.result = wide[31:0];
                    if (!sgn && wide[32])
                        o.st = ST_OVERFLOW;
                    if (sgn && a[31] == b[31] && o.result[31] != a[31])
                        o.st = ST_OVERFLOW;
                end
                OP_SUB:
                begin
                    if (!sgn && b > a)
                        o.st = ST_UNDERFLOW;
                    else
                        o.result = a - b;
                end
                OP_MUL:
                begin
                    prod     = {32'd0, a} * {32'd0, b};
                    o.result = prod[31:0];
                end
                OP_DIV:
                begin
                    if (b == '0)
                        o.st = ST_DIVZERO;
                    else if (!sgn)
                        o.result = a / b;
                    else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                        o.st = ST_OVERFLOW;
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q  = ma / mb;
                        o.result = (a[31] ^ b[31]) ? -q : q;
                    end
                end
                OP_AND: o.result = a & b;
                OP_OR:  o.result = a | b;
                default: o.result = a ^ b;
            endcase
        end
        if (o.st != ST_OK)
            o.result = '0;
        o.wr = (o.st == ST_OK);
        return o;
    endfunction

    // Offer one transaction; returns once it has been accepted.
    task automatic send_instr(op_t op, logic [7:0] prm, logic [31:0] a, logic [31:0] b,
                              outcome_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        action    <= op;
        param     <= prm;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_outcomes.push_back(want);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(15);
            5: return -$urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_param();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 8'd0;
        if (r < 90)
            return 8'd1;
        return 8'($urandom_range(255));
    endfunction

    // Receiver: pops at random, honors the long hold-off, checks each transaction.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected transaction result=%h wr=%b status=%0d",
                             $time, result, write_dest, status);
                    n_errors = n_errors + 1;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result !== want.result)
                    begin
                        $display("%0t: result expected %h actual %h",
                                 $time, want.result, result);
                        n_errors = n_errors + 1;
                    end
                    if (write_dest !== want.wr)
                    begin
                        $display("%0t: write_dest expected %b actual %b",
                                 $time, want.wr, write_dest);
                        n_errors = n_errors + 1;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        n_errors = n_errors + 1;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        vector_t  vectors[$];
        outcome_t want;
        int       phase;
        int       tail_wait;

        // Directed rows; known outcomes only where obvious.
        vectors = '{
            '{OP_NOP, 8'd0,   32'h1234, 32'h5678, 1, 32'h0, 0, ST_OK},
            '{OP_NOP, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 0, ST_OK},
            '{OP_ADD, 8'd0,   32'hFFFF_FFFF, 32'h1, 1, 32'h0, 0, ST_OVERFLOW},
            '{OP_ADD, 8'd1,   32'h7FFF_FFFF, 32'h1, 1, 32'h0, 0, ST_OVERFLOW},
            '{OP_ADD, 8'd1,   32'h8000_0000, 32'h8000_0000, 1, 32'h0, 0, ST_OVERFLOW},
            '{OP_ADD, 8'd0,   32'hFFFF_FFFE, 32'h1, 1, 32'hFFFF_FFFF, 1, ST_OK},
            '{OP_ADD, 8'd2,   32'h1, 32'h1, 1, 32'h0, 0, ST_BADPARAM},
            '{OP_SUB, 8'd0,   32'h0, 32'h1, 1, 32'h0, 0, ST_UNDERFLOW},
            '{OP_SUB, 8'd1,   32'h0, 32'h1, 1, 32'hFFFF_FFFF, 1, ST_OK},
            '{OP_SUB, 8'd1,   32'h8000_0000, 32'h1, 0, 32'h0, 0, ST_OK},
            '{OP_MUL, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h1, 1, ST_OK},
            '{OP_MUL, 8'd1,   32'h8000_0000, 32'h2, 1, 32'h0, 1, ST_OK},
            '{OP_MUL, 8'd255, 32'h3, 32'h3, 1, 32'h0, 0, ST_BADPARAM},
            '{OP_DIV, 8'd0,   32'h5, 32'h0, 1, 32'h0, 0, ST_DIVZERO},
            '{OP_DIV, 8'd1,   32'h5, 32'h0, 1, 32'h0, 0, ST_DIVZERO},
            '{OP_DIV, 8'd1,   32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h0, 0, ST_OVERFLOW},
            '{OP_DIV, 8'd0,   32'h8000_0000, 32'hFFFF_FFFF, 0, 32'h0, 0, ST_OK},
            '{OP_DIV, 8'd1,   32'hFFFF_FFF9, 32'h2, 1, 32'hFFFF_FFFD, 1, ST_OK},
            '{OP_DIV, 8'd1,   32'h7, 32'hFFFF_FFFE, 0, 32'h0, 0, ST_OK},
            '{OP_AND, 8'd0,   32'hF0F0_F0F0, 32'hFF00_FF00, 0, 32'h0, 0, ST_OK},
            '{OP_AND, 8'd1,   32'h1, 32'h1, 1, 32'h0, 0, ST_BADPARAM},
            '{OP_OR,  8'd0,   32'h0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, ST_OK},
            '{OP_OR,  8'd128, 32'h1, 32'h1, 1, 32'h0, 0, ST_BADPARAM},
            '{OP_XOR, 8'd0,   32'hFFFF_FFFF, 32'hAAAA_5555, 0, 32'h0, 0, ST_OK},
            '{OP_XOR, 8'd1,   32'h1, 32'h1, 1, 32'h0, 0, ST_BADPARAM}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].known)
            begin
                want.result = vectors[i].result;
                want.wr     = vectors[i].wr;
                want.st     = vectors[i].st;
            end
            else
                want = alu_outcome(vectors[i].op, vectors[i].param,
                                   vectors[i].a, vectors[i].b);
            send_instr(vectors[i].op, vectors[i].param, vectors[i].a, vectors[i].b, want);
        end

        // Random traffic across idle/stall phases; phase 4 also forces a long
        // receiver hold-off so the pipeline and queue fill and full asserts.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            op_t         op;
            logic [7:0]  prm;
            logic [31:0] a;
            logic [31:0] b;
            phase = n / (N_RANDOM / 5);
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                3: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            if (n == 4 * (N_RANDOM / 5))
                hold_off <= 200;
            op  = op_t'($urandom_range(7));
            prm = rand_param();
            a   = rand_operand();
            b   = rand_operand();
            send_instr(op, prm, a, b, alu_outcome(op, prm, a, b));
        end
        push <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        // Let any stray transaction surface.
        tail_wait = 0;
        while (tail_wait < TAIL)
        begin
            @(posedge clk);
            tail_wait++;
        end

        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
